FILE: rtl/dtq_pkg.sv
package dtq_pkg;

    // Queue size and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request opcodes.
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_POLL   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SET_REPLY    = 2'd0;
    localparam logic [1:0] KIND_CANCEL_REPLY = 2'd1;
    localparam logic [1:0] KIND_EXPIRED      = 2'd2;
    localparam logic [1:0] KIND_POLL_DONE    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Operations of the shared arithmetic unit.
    typedef logic [1:0] alu_op_t;
    localparam alu_op_t ALU_SADD = 2'd0;
    localparam alu_op_t ALU_LE   = 2'd1;
    localparam alu_op_t ALU_SUB  = 2'd2;
    localparam alu_op_t ALU_EQ   = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] delay_ms;
        logic [15:0] cancel_id;
        logic [31:0] user_tag;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] timer_id;
        logic [31:0] tag_out;
        logic [31:0] wait_ms;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] id;
        logic [31:0] tag;
    } entry_t;

    // Edit command from the sequencer to the entry store.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] idx;
        entry_t           wdata;
    } store_cmd_t;

endpackage

FILE: rtl/dtq_alu.sv
module dtq_alu (
    input  dtq_pkg::alu_op_t op,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic [31:0]      res,
    output logic             flag
);
    import dtq_pkg::*;

    logic [32:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};

    // One adder, subtractor and comparator shared by the add, scan, poll and wait steps of the sequencer.
    always_comb
    begin
        res  = '0;
        flag = 1'b0;
        unique case (op)
            ALU_SADD:
            begin
                res = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            ALU_LE:
            begin
                flag = (a <= b);
            end
            ALU_SUB:
            begin
                res = a - b;
            end
            ALU_EQ:
            begin
                flag = (a == b);
            end
            default:
            begin
                res  = '0;
                flag = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/dtq_store.sv
module dtq_store (
    input  logic                           clk,
    input  dtq_pkg::store_cmd_t            cmd,
    input  logic [dtq_pkg::IDX_W-1:0]      rd_idx,
    output dtq_pkg::entry_t                rd_data
);
    import dtq_pkg::*;

    entry_t entry_reg [CAPACITY];

    // Single read port, chosen by the sequencer.
    assign rd_data = entry_reg[rd_idx];

    // Each slot takes the new entry, its lower neighbor on insert, or its
    // upper neighbor on remove. Slots past the fill level hold don't-care data.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_slot
        entry_t lower;
        entry_t upper;

        if (i > 0)
        begin : g_lo
            assign lower = entry_reg[i-1];
        end
        else
        begin : g_lo0
            assign lower = entry_reg[i];
        end

        if (i < CAPACITY - 1)
        begin : g_up
            assign upper = entry_reg[i+1];
        end
        else
        begin : g_upn
            assign upper = entry_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.ins)
            begin
                if (IDX_W'(i) == cmd.idx)
                begin
                    entry_reg[i] <= cmd.wdata;
                end
                else if (IDX_W'(i) > cmd.idx)
                begin
                    entry_reg[i] <= lower;
                end
            end
            else if (cmd.rem)
            begin
                if (IDX_W'(i) >= cmd.idx)
                begin
                    entry_reg[i] <= upper;
                end
            end
        end
    end

endmodule

FILE: rtl/deadline_timer_queue_unit.sv
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | dtq_pkg::req_t (opcode, delay, id, tag, now)
// rsp     | out       | rsp_valid / rsp_ready  | dtq_pkg::rsp_t (kind, status, id, tag, wait, last)
//
// One item at a time; a sequencer drives one shared adder/comparator over the
// entry store, one entry per cycle. Set runs add, a scan of up to count+1
// entries and emit; cancel scans up to count entries and emits; poll emits
// each expired timer, then a done result. Reset clears the fill count and
// control state and sets the id counter to one; entry contents are not
// cleared. A new item is taken in the idle state even while the previous
// last result waits; a stalled output holds the sequencer in its emit step.
module deadline_timer_queue_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  dtq_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output dtq_pkg::rsp_t   rsp
);
    import dtq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD      = 3'd1;
    localparam logic [2:0] S_SET_SCAN = 3'd2;
    localparam logic [2:0] S_CAN_SCAN = 3'd3;
    localparam logic [2:0] S_POLL     = 3'd4;
    localparam logic [2:0] S_WAIT     = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [15:0]      next_id_reg, next_id_next;
    logic [31:0]      now_reg, now_next;
    logic [30:0]      delay_reg, delay_next;
    logic [15:0]      cid_reg, cid_next;
    logic [31:0]      tag_reg, tag_next;
    logic [31:0]      dl_reg, dl_next;
    rsp_t             res_reg, res_next;
    rsp_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    store_cmd_t       cmd;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_data;
    alu_op_t          alu_op;
    logic [31:0]      alu_a;
    logic [31:0]      alu_b;
    logic [31:0]      alu_res;
    logic             alu_flag;

    dtq_store u_store (
        .clk     (clk),
        .cmd     (cmd),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    dtq_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .res  (alu_res),
        .flag (alu_flag)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        next_id_next   = next_id_reg;
        now_next       = now_reg;
        delay_next     = delay_reg;
        cid_next       = cid_reg;
        tag_next       = tag_reg;
        dl_next        = dl_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        rd_idx         = idx_reg[IDX_W-1:0];
        alu_op         = ALU_LE;
        alu_a          = rd_data.deadline;
        alu_b          = dl_reg;

        // The output register empties when its item is taken.
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    now_next   = req.now_ms;
                    delay_next = req.delay_ms;
                    cid_next   = req.cancel_id;
                    tag_next   = req.user_tag;
                    idx_next   = '0;
                    res_next   = '0;
                    unique case (req.opcode)
                        OP_SET:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_next.kind   = KIND_SET_REPLY;
                                res_next.status = ST_FULL;
                                res_next.last   = 1'b1;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        OP_CANCEL:
                        begin
                            state_next = S_CAN_SCAN;
                        end
                        OP_POLL:
                        begin
                            state_next = S_POLL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                alu_op     = ALU_SADD;
                alu_a      = now_reg;
                alu_b      = {1'b0, delay_reg};
                dl_next    = alu_res;
                state_next = S_SET_SCAN;
            end
            S_SET_SCAN:
            begin
                // Walk past every entry due at or before the new deadline.
                alu_op = ALU_LE;
                alu_a  = rd_data.deadline;
                alu_b  = dl_reg;
                if ((idx_reg < count_reg) && alu_flag)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    cmd.ins            = 1'b1;
                    cmd.idx            = idx_reg[IDX_W-1:0];
                    cmd.wdata.deadline = dl_reg;
                    cmd.wdata.id       = next_id_reg;
                    cmd.wdata.tag      = tag_reg;
                    count_next         = count_reg + 1'b1;
                    next_id_next       = (next_id_reg == 16'hFFFF) ? 16'd1
                                                                   : next_id_reg + 16'd1;
                    res_next           = '0;
                    res_next.kind      = KIND_SET_REPLY;
                    res_next.status    = ST_OK;
                    res_next.timer_id  = next_id_reg;
                    res_next.last      = 1'b1;
                    state_next         = S_EMIT;
                end
            end
            S_CAN_SCAN:
            begin
                alu_op = ALU_EQ;
                alu_a  = {16'd0, rd_data.id};
                alu_b  = {16'd0, cid_reg};
                if (idx_reg == count_reg)
                begin
                    res_next        = '0;
                    res_next.kind   = KIND_CANCEL_REPLY;
                    res_next.status = ST_NOT_FOUND;
                    res_next.last   = 1'b1;
                    state_next      = S_EMIT;
                end
                else if (alu_flag)
                begin
                    cmd.rem         = 1'b1;
                    cmd.idx         = idx_reg[IDX_W-1:0];
                    count_next      = count_reg - 1'b1;
                    res_next        = '0;
                    res_next.kind   = KIND_CANCEL_REPLY;
                    res_next.status = ST_OK;
                    res_next.last   = 1'b1;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_POLL:
            begin
                // Look at the head entry only.
                rd_idx = '0;
                alu_op = ALU_LE;
                alu_a  = rd_data.deadline;
                alu_b  = now_reg;
                if (count_reg == '0)
                begin
                    res_next      = '0;
                    res_next.kind = KIND_POLL_DONE;
                    res_next.last = 1'b1;
                    state_next    = S_EMIT;
                end
                else if (alu_flag)
                begin
                    cmd.rem           = 1'b1;
                    cmd.idx           = '0;
                    count_next        = count_reg - 1'b1;
                    res_next          = '0;
                    res_next.kind     = KIND_EXPIRED;
                    res_next.timer_id = rd_data.id;
                    res_next.tag_out  = rd_data.tag;
                    state_next        = S_EMIT;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                rd_idx           = '0;
                alu_op           = ALU_SUB;
                alu_a            = rd_data.deadline;
                alu_b            = now_reg;
                res_next         = '0;
                res_next.kind    = KIND_POLL_DONE;
                res_next.wait_ms = alu_res;
                res_next.last    = 1'b1;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                // Hand the result to the output register once it has room.
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = res_reg.last ? S_IDLE : S_POLL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            next_id_reg   <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        delay_reg <= delay_next;
        cid_reg   <= cid_next;
        tag_reg   <= tag_next;
        dl_reg    <= dl_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // The fill level never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("timer queue fill level above capacity");

    // Ids handed out are never zero.
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != 16'd0)
        else $error("timer id counter reached zero");

    // An insert scan only runs while there is room.
    a_set_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SET_SCAN |-> count_reg < CNT_W'(CAPACITY))
        else $error("insert scan on a full queue");

    // The fill level moves by at most one entry per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1
        || count_reg == $past(count_reg) - 1'b1)
        else $error("timer queue fill level jumped");

    // A result ready to go reaches the output in the next cycle.
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!out_valid_reg || rsp_ready)) |=> out_valid_reg)
        else $error("result lost on its way to the output");

endmodule
